// File: rtl/bpmc_pkg.sv
// Shared constants and types for the banded position motor controller.
`timescale 1ns / 1ps

package bpmc_pkg;

    // Default sensor resolution.
    localparam int ADC_BITS_DEF = 10;

    // Field widths fixed by the item formats.
    localparam int OPCODE_W   = 2;
    localparam int POS_W      = 7;
    localparam int CFG_W      = 14;
    localparam int TOL_W      = 10;
    localparam int DEV_W      = 7;
    localparam int TX_W       = 8;
    localparam int RP_W       = 9;
    localparam int OUT_DATA_W = 24;
    localparam int SPAN_W     = CFG_W + 1;
    localparam int SPEED_W    = 13;
    localparam int MAG_W      = 12;
    localparam int CFG_IDX_W  = 2;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OP_MOVE   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RESET  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_ANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_ANGLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE     = 2'd3;

    // Serial command bytes.
    localparam logic [TX_W-1:0] CMD_SYNC        = 8'hAA;
    localparam logic [TX_W-1:0] CMD_EXIT_SAFE   = 8'h03;
    localparam logic [TX_W-1:0] CMD_FORWARD     = 8'h85;
    localparam logic [TX_W-1:0] CMD_REVERSE     = 8'h86;

    // Sensor conversion: angle = floor((adc - 102) * 450 / 64), Q4 degrees.
    localparam int ADC_LOW    = 100;
    localparam int ADC_OFFSET = 102;
    localparam int ADC_GAIN   = 450;
    localparam int ANG_SHIFT  = 6;
    localparam int ANG_FLOOR  = -16;

    // Speed bands on the angle error, Q4 degrees.
    localparam int BAND_HI    = 1440;
    localparam int BAND_MID   = 640;
    localparam int BAND_LO    = 240;
    localparam int SPEED_FAST = 3600;
    localparam int SPEED_MID  = 1800;
    localparam int SPEED_SLOW = 900;
    localparam int SPEED_MIN  = 500;

    localparam int PCT_SCALE  = 100;
    localparam int GOAL_MAX   = 8191;
    localparam int GOAL_MIN   = -8192;
    localparam int RP_MAX     = 255;
    localparam int RP_MIN     = -256;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// File: rtl/bpmc_div.sv
// Bit-serial signed divider with truncation towards zero, shared by the sequencer.
`timescale 1ns / 1ps

module bpmc_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 15
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic signed [NUM_W:0]   quot,
    output bpmc_pkg::div_sts_t      sts
);
    import bpmc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] q_next;
    logic signed [NUM_W:0] q_pos;

    // The most negative value maps onto its own bit pattern, read as unsigned.
    assign num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_mag  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

    assign trial    = {rem_reg, q_reg[NUM_W-1]};
    assign diff     = trial - {1'b0, d_reg};
    assign ge       = (trial >= {1'b0, d_reg});
    assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign q_next   = {q_reg[NUM_W-2:0], ge};

    assign q_pos    = $signed({1'b0, q_reg});
    assign quot     = neg_reg ? -q_pos : q_pos;

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                neg_reg  <= num[NUM_W-1] ^ den[DEN_W-1];
                q_reg    <= num_mag;
                d_reg    <= den_mag;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                q_reg   <= q_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
        else $error("divider started while busy");
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> cnt_reg != '0)
        else $error("divider busy with an empty step count");

endmodule

// File: rtl/banded_position_motor_controller.sv
// Top level of the banded position motor controller: sequencer, shared multiplier and I/O.
`timescale 1ns / 1ps

// The controller drives a serial motor controller towards a goal angle. A start-move
// item (tuser opcode 0) sets the goal to zero_angle plus the target percentage of the
// span to full_angle; each later sensor sample (opcode 1) is turned into an angle in
// Q4 degrees, and while the error is above angle_tolerance a five-byte speed command
// is sent whenever the banded speed changes. Once within tolerance a stop command is
// sent (unless the motor is already stopped) followed by a report transfer carrying
// the reached position. Opcode 2 sends the exit-safe-start command. Items are taken
// one at a time: tready is high only while the sequencer is idle. All arithmetic runs
// through one multiplier and one bit-serial divider that yields one quotient bit per
// cycle; the product width is 30 bits for 10-bit samples. Command bytes wait while
// the output side holds tready low. Configuration writes are accepted in any cycle.
module banded_position_motor_controller #(
    parameter int ADC_BITS = bpmc_pkg::ADC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input items.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: target_position[6:0], adc_sample[ADC_BITS+6:7], zero padding above.
    input  logic [((ADC_BITS+14)/8)*8-1:0]     s_axis_tdata,
    // tuser: opcode[1:0].
    input  logic [bpmc_pkg::OPCODE_W-1:0]      s_axis_tuser,
    // Result items.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: tx_byte[7:0], reached_position[16:8], zero padding above.
    output logic [bpmc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: out_kind[0].
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast,
    // Configuration writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpmc_pkg::CFG_W-1:0]         cfg_data
);
    import bpmc_pkg::*;

    localparam int IN_W  = ((ADC_BITS + 14) / 8) * 8;
    localparam int ANG_W = ADC_BITS + 4;
    localparam int ERR_W = ((ANG_W > CFG_W) ? ANG_W : CFG_W) + 1;
    localparam int MA_W  = ERR_W;
    localparam int MB_W  = SPAN_W;
    localparam int P_W   = MA_W + MB_W;
    localparam int Q_W   = P_W + 1;
    localparam int G_W   = Q_W + 1;
    localparam int IDX_W = 3;

    // Byte positions inside a serial command.
    localparam logic [IDX_W-1:0] BYTE_SYNC   = 3'd0;
    localparam logic [IDX_W-1:0] BYTE_DEVICE = 3'd1;
    localparam logic [IDX_W-1:0] BYTE_CMD    = 3'd2;
    localparam logic [IDX_W-1:0] BYTE_LOW    = 3'd3;
    localparam logic [IDX_W-1:0] BYTE_HIGH   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_GOAL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MUL_ANG,
        S_ANG,
        S_EVAL,
        S_REP_PREP,
        S_MUL_REP,
        S_BYTE,
        S_REPORT,
        S_OUT_WAIT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic signed [CFG_W-1:0] zero_angle_reg;
    logic signed [CFG_W-1:0] full_angle_reg;
    logic [TOL_W-1:0]        tolerance_reg;
    logic [DEV_W-1:0]        device_reg;

    // Controller state.
    logic signed [CFG_W-1:0]   goal_reg;
    logic signed [SPEED_W-1:0] sent_reg;
    logic                      moving_reg;

    // Working registers.
    logic [OPCODE_W-1:0]       op_reg;
    logic [POS_W-1:0]          pos_reg;
    logic [ADC_BITS-1:0]       adc_reg;
    logic signed [ANG_W-1:0]   ang_reg;
    logic signed [P_W-1:0]     prod_reg;
    logic                      purpose_goal_reg;
    logic                      cmd_reset_reg;
    logic                      report_after_reg;
    logic signed [SPEED_W-1:0] cmd_speed_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [RP_W-1:0]    rp_reg;

    // Output registers.
    logic                      m_valid_reg;
    logic [OUT_DATA_W-1:0]     m_data_reg;
    logic                      m_user_reg;
    logic                      m_last_reg;

    // Datapath signals.
    logic signed [SPAN_W-1:0]   span;
    logic signed [ADC_BITS:0]   adc_rel;
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [ANG_W-1:0]    ang_next;
    logic signed [ERR_W-1:0]    err;
    logic [ERR_W-1:0]           err_mag;
    logic                       far;
    logic [MAG_W-1:0]           band_mag;
    logic signed [SPEED_W-1:0]  spd_next;
    logic signed [MB_W-1:0]     div_den;
    logic signed [Q_W-1:0]      div_q;
    div_sts_t                   div_sts;
    logic signed [G_W-1:0]      gsum;
    logic signed [CFG_W-1:0]    goal_next;
    logic signed [RP_W-1:0]     rp_next;
    logic [MAG_W-1:0]           cmd_mag;
    logic [IDX_W-1:0]           last_idx;
    logic [TX_W-1:0]            byte_sel;

    assign span = SPAN_W'(full_angle_reg) - SPAN_W'(zero_angle_reg);

    // ------------------------------------------------------------------
    // Configuration port: always ready, a write lands in the next cycle.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_angle_reg <= CFG_W'(0);
            full_angle_reg <= CFG_W'(5760);
            tolerance_reg  <= TOL_W'(32);
            device_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ZERO_ANGLE: zero_angle_reg <= $signed(cfg_data);
                REG_FULL_ANGLE: full_angle_reg <= $signed(cfg_data);
                REG_TOLERANCE:  tolerance_reg  <= cfg_data[TOL_W-1:0];
                REG_DEVICE:     device_reg     <= cfg_data[DEV_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier. Its operands are chosen by the sequencer state:
    // position times span for a goal, offset sample times the sensor gain
    // for an angle, and angle above zero times one hundred for a report.
    // ------------------------------------------------------------------
    assign adc_rel = $signed({1'b0, adc_reg}) - (ADC_BITS + 1)'(ADC_OFFSET);

    always_comb
    begin
        case (state_reg)
            S_MUL_GOAL:
            begin
                mul_a = MA_W'($signed({1'b0, pos_reg}));
                mul_b = span;
            end
            S_MUL_ANG:
            begin
                mul_a = MA_W'(adc_rel);
                mul_b = MB_W'(ADC_GAIN);
            end
            default:
            begin
                mul_a = MA_W'(ang_reg) - MA_W'(zero_angle_reg);
                mul_b = MB_W'(PCT_SCALE);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= P_W'(mul_a) * P_W'(mul_b);
    end

    // Samples below the usable range read as minus one degree; otherwise the
    // arithmetic shift gives the floor of the division by 64.
    assign ang_next = (adc_reg < ADC_BITS'(ADC_LOW)) ? ANG_W'(ANG_FLOOR)
                                                      : ANG_W'(prod_reg >>> ANG_SHIFT);

    // ------------------------------------------------------------------
    // Shared divider: by one hundred for the goal, by the span for a report.
    // ------------------------------------------------------------------
    assign div_den = purpose_goal_reg ? MB_W'(PCT_SCALE) : span;

    bpmc_div #(
        .NUM_W (P_W),
        .DEN_W (MB_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DIV_GO),
        .num   (prod_reg),
        .den   (div_den),
        .quot  (div_q),
        .sts   (div_sts)
    );

    // The goal saturates to the 14-bit signed range, the report to 9 bits.
    assign gsum = G_W'(div_q) + G_W'(zero_angle_reg);

    always_comb
    begin
        if (gsum > G_W'(GOAL_MAX))
            goal_next = CFG_W'(GOAL_MAX);
        else if (gsum < G_W'(GOAL_MIN))
            goal_next = CFG_W'(GOAL_MIN);
        else
            goal_next = CFG_W'(gsum);

        if (div_q > Q_W'(RP_MAX))
            rp_next = RP_W'(RP_MAX);
        else if (div_q < Q_W'(RP_MIN))
            rp_next = RP_W'(RP_MIN);
        else
            rp_next = RP_W'(div_q);
    end

    // ------------------------------------------------------------------
    // Error banding. The sign of the speed follows the sign of the error.
    // ------------------------------------------------------------------
    assign err     = ERR_W'(goal_reg) - ERR_W'(ang_reg);
    assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    assign far     = (err_mag > ERR_W'(tolerance_reg));

    always_comb
    begin
        if (err_mag > ERR_W'(BAND_HI))
            band_mag = MAG_W'(SPEED_FAST);
        else if (err_mag > ERR_W'(BAND_MID))
            band_mag = MAG_W'(SPEED_MID);
        else if (err_mag > ERR_W'(BAND_LO))
            band_mag = MAG_W'(SPEED_SLOW);
        else
            band_mag = MAG_W'(SPEED_MIN);
    end

    assign spd_next = err[ERR_W-1] ? -$signed({1'b0, band_mag}) : $signed({1'b0, band_mag});

    // ------------------------------------------------------------------
    // Command byte selection.
    // ------------------------------------------------------------------
    assign cmd_mag  = cmd_speed_reg[SPEED_W-1] ? MAG_W'(-cmd_speed_reg)
                                               : cmd_speed_reg[MAG_W-1:0];
    assign last_idx = cmd_reset_reg ? BYTE_CMD : BYTE_HIGH;

    always_comb
    begin
        case (idx_reg)
            BYTE_SYNC:   byte_sel = CMD_SYNC;
            BYTE_DEVICE: byte_sel = {1'b0, device_reg};
            BYTE_CMD:
            begin
                if (cmd_reset_reg)
                    byte_sel = CMD_EXIT_SAFE;
                else if (cmd_speed_reg[SPEED_W-1])
                    byte_sel = CMD_REVERSE;
                else
                    byte_sel = CMD_FORWARD;
            end
            BYTE_LOW:    byte_sel = {3'b000, cmd_mag[4:0]};
            BYTE_HIGH:   byte_sel = {1'b0, cmd_mag[MAG_W-1:5]};
            default:     byte_sel = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer. One item is worked through at a time; results leave
    // through the output register, one transfer per visit of S_OUT_WAIT.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            goal_reg         <= '0;
            sent_reg         <= '0;
            moving_reg       <= 1'b0;
            purpose_goal_reg <= 1'b0;
            cmd_reset_reg    <= 1'b0;
            report_after_reg <= 1'b0;
            idx_reg          <= '0;
            m_valid_reg      <= 1'b0;
            m_user_reg       <= 1'b0;
            m_last_reg       <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg    <= s_axis_tuser;
                        pos_reg   <= s_axis_tdata[POS_W-1:0];
                        adc_reg   <= s_axis_tdata[ADC_BITS+POS_W-1:POS_W];
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    case (op_reg)
                        OP_MOVE:   state_reg <= S_MUL_GOAL;
                        OP_SAMPLE: state_reg <= moving_reg ? S_MUL_ANG : S_IDLE;
                        OP_RESET:
                        begin
                            // Exit-safe-start leaves the motor stopped.
                            cmd_reset_reg    <= 1'b1;
                            report_after_reg <= 1'b0;
                            idx_reg          <= BYTE_SYNC;
                            sent_reg         <= '0;
                            state_reg        <= S_BYTE;
                        end
                        default:   state_reg <= S_IDLE;
                    endcase
                end
                S_MUL_GOAL:
                begin
                    purpose_goal_reg <= 1'b1;
                    state_reg        <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_sts.done)
                    begin
                        if (purpose_goal_reg)
                        begin
                            goal_reg   <= goal_next;
                            moving_reg <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            rp_reg    <= rp_next;
                            state_reg <= S_REPORT;
                        end
                    end
                end
                S_MUL_ANG:
                begin
                    state_reg <= S_ANG;
                end
                S_ANG:
                begin
                    ang_reg   <= ang_next;
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    cmd_reset_reg <= 1'b0;
                    idx_reg       <= BYTE_SYNC;
                    if (far)
                    begin
                        report_after_reg <= 1'b0;
                        if (spd_next != sent_reg)
                        begin
                            cmd_speed_reg <= spd_next;
                            sent_reg      <= spd_next;
                            state_reg     <= S_BYTE;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        // Within tolerance: stop if still turning, then report.
                        report_after_reg <= 1'b1;
                        if (sent_reg != '0)
                        begin
                            cmd_speed_reg <= '0;
                            sent_reg      <= '0;
                            state_reg     <= S_BYTE;
                        end
                        else
                        begin
                            state_reg <= S_REP_PREP;
                        end
                    end
                end
                S_REP_PREP:
                begin
                    // With an empty span the reached position reads as zero.
                    if (span == '0)
                    begin
                        rp_reg    <= '0;
                        state_reg <= S_REPORT;
                    end
                    else
                    begin
                        state_reg <= S_MUL_REP;
                    end
                end
                S_MUL_REP:
                begin
                    purpose_goal_reg <= 1'b0;
                    state_reg        <= S_DIV_GO;
                end
                S_BYTE:
                begin
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= OUT_DATA_W'(byte_sel);
                    m_user_reg  <= 1'b0;
                    m_last_reg  <= (idx_reg == last_idx) && !report_after_reg;
                    state_reg   <= S_OUT_WAIT;
                end
                S_REPORT:
                begin
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= OUT_DATA_W'({rp_reg, {TX_W{1'b0}}});
                    m_user_reg  <= 1'b1;
                    m_last_reg  <= 1'b1;
                    moving_reg  <= 1'b0;
                    state_reg   <= S_OUT_WAIT;
                end
                S_OUT_WAIT:
                begin
                    if (m_axis_tready)
                    begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg)
                            state_reg <= S_IDLE;
                        else if (idx_reg == last_idx)
                            state_reg <= S_REP_PREP;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_BYTE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> state_reg == S_OUT_WAIT)
        else $error("result offered outside the output wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && !moving_reg))
        else $error("report not final or move still active");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
            |=> (state_reg == S_BYTE || state_reg == S_REP_PREP))
        else $error("command sequence ended without a final transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_WAIT && !purpose_goal_reg) |-> span != '0)
        else $error("position division started with an empty span");

endmodule

// File: bench/testbench.sv
// Self-checking bench for the banded position motor controller, with its scoreboard class.
`timescale 1ns / 1ps

import bpmc_pkg::*;

// One result transfer as the bench expects it.
typedef struct {
    logic                   kind;
    logic [TX_W-1:0]        tx;
    logic signed [RP_W-1:0] pos;
    logic                   last;
} motor_result_t;

// Keeps its own copy of the controller state and settings, works out the command bytes
// and reports that each accepted item should cause, and checks them in order.
class motor_result_scoreboard;
    logic signed [CFG_W-1:0]   zero_angle;
    logic signed [CFG_W-1:0]   full_angle;
    logic [TOL_W-1:0]          tolerance;
    logic [DEV_W-1:0]          device;
    logic signed [CFG_W-1:0]   goal_angle;
    logic signed [SPEED_W-1:0] speed_sent;
    bit                        moving;
    motor_result_t             awaited[$];
    int                        errors;
    int                        results_checked;

    function new();
        zero_angle      = '0;
        full_angle      = 14'sd5760;
        tolerance       = 10'd32;
        device          = '0;
        goal_angle      = '0;
        speed_sent      = '0;
        moving          = 1'b0;
        errors          = 0;
        results_checked = 0;
    endfunction

    function void store_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
        case (index)
            REG_ZERO_ANGLE: zero_angle = value;
            REG_FULL_ANGLE: full_angle = value;
            REG_TOLERANCE:  tolerance  = value[TOL_W-1:0];
            REG_DEVICE:     device     = value[DEV_W-1:0];
            default: ;
        endcase
    endfunction

    function void push_byte(logic [TX_W-1:0] value);
        motor_result_t item;
        item.kind = 1'b0;
        item.tx   = value;
        item.pos  = '0;
        item.last = 1'b0;
        awaited.push_back(item);
    endfunction

    // A speed command goes out only when the speed differs from the one last sent.
    function void push_speed(int speed);
        int held;
        int mag;
        held = speed_sent;
        if (speed == held)
            return;
        mag = (speed < 0) ? -speed : speed;
        push_byte(CMD_SYNC);
        push_byte({1'b0, device});
        push_byte((speed < 0) ? CMD_REVERSE : CMD_FORWARD);
        push_byte({3'b000, mag[4:0]});
        push_byte(mag[12:5]);
        speed_sent = speed[SPEED_W-1:0];
    endfunction

    // Q4 degrees, rounded towards minus infinity; readings below ADC_LOW pin to -1 degree.
    function int sensor_angle(logic [ADC_BITS_DEF-1:0] adc);
        int raw;
        raw = adc;
        if (raw < ADC_LOW)
            return ANG_FLOOR;
        return ((raw - ADC_OFFSET) * ADC_GAIN) >>> ANG_SHIFT;
    endfunction

    // Returns 1 when the block acts on the item, 0 when it is ignored.
    function bit note_item(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] target,
                           logic [ADC_BITS_DEF-1:0] adc);
        longint        goal;
        longint        span;
        longint        position;
        int            zero_i;
        int            full_i;
        int            goal_i;
        int            tol_i;
        int            target_i;
        int            angle;
        int            error;
        int            magnitude;
        int            first;
        motor_result_t report_item;
        zero_i   = zero_angle;
        full_i   = full_angle;
        goal_i   = goal_angle;
        tol_i    = tolerance;
        target_i = target;
        first    = awaited.size();
        case (op)
            OP_MOVE:
            begin
                goal = zero_i + (longint'(target_i) * (full_i - zero_i)) / PCT_SCALE;
                if (goal > GOAL_MAX)
                    goal = GOAL_MAX;
                if (goal < GOAL_MIN)
                    goal = GOAL_MIN;
                goal_angle = goal[CFG_W-1:0];
                moving     = 1'b1;
            end
            OP_SAMPLE:
            begin
                if (!moving)
                    return 1'b0;
                angle = sensor_angle(adc);
                error = goal_i - angle;
                if (error < 0)
                    error = -error;
                if (error > tol_i)
                begin
                    magnitude = (error > BAND_HI)  ? SPEED_FAST :
                                (error > BAND_MID) ? SPEED_MID  :
                                (error > BAND_LO)  ? SPEED_SLOW : SPEED_MIN;
                    push_speed((goal_i > angle) ? magnitude : -magnitude);
                end
                else
                begin
                    push_speed(0);
                    span     = full_i - zero_i;
                    position = 0;
                    if (span != 0)
                        position = (longint'(PCT_SCALE) * (angle - zero_i)) / span;
                    if (position > RP_MAX)
                        position = RP_MAX;
                    if (position < RP_MIN)
                        position = RP_MIN;
                    report_item.kind = 1'b1;
                    report_item.tx   = '0;
                    report_item.pos  = position[RP_W-1:0];
                    report_item.last = 1'b0;
                    awaited.push_back(report_item);
                    moving = 1'b0;
                end
            end
            OP_RESET:
            begin
                push_byte(CMD_SYNC);
                push_byte({1'b0, device});
                push_byte(CMD_EXIT_SAFE);
                speed_sent = '0;
            end
            default:
                return 1'b0;
        endcase
        if (awaited.size() > first)
            awaited[awaited.size() - 1].last = 1'b1;
        return 1'b1;
    endfunction

    function void check_result(logic kind, logic [TX_W-1:0] tx, logic signed [RP_W-1:0] pos,
                               logic last);
        motor_result_t want;
        results_checked++;
        if (awaited.size() == 0)
        begin
            $error("unexpected result transfer: out_kind %0d tx_byte 0x%02h position %0d",
                   kind, tx, pos);
            errors++;
            return;
        end
        want = awaited.pop_front();
        if (kind !== want.kind)
        begin
            $error("out_kind: expected %0d, actual %0d", want.kind, kind);
            errors++;
        end
        if (tx !== want.tx)
        begin
            $error("tx_byte: expected 0x%02h, actual 0x%02h", want.tx, tx);
            errors++;
        end
        if (pos !== want.pos)
        begin
            $error("reached_position: expected %0d, actual %0d", want.pos, pos);
            errors++;
        end
        if (last !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, last);
            errors++;
        end
    endfunction

    function int outstanding();
        return awaited.size();
    endfunction
endclass

module testbench;

    localparam int ADC_W      = ADC_BITS_DEF;
    localparam int IN_DATA_W  = ((POS_W + ADC_W + 7) / 8) * 8;
    localparam int ADC_TOP    = (1 << ADC_W) - 1;
    // A start move keeps the block busy with no result to show for it, so the bench
    // waits QUIET_CYCLES after the last result before touching registers.
    localparam int QUIET_CYCLES    = 120;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int RANDOM_PHASES   = 4;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic [OPCODE_W-1:0]     s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    motor_result_scoreboard board;
    bit tx_no_gaps;
    bit rx_no_stalls;
    int items_sent;
    int settings_used;

    banded_position_motor_controller #(
        .ADC_BITS(ADC_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run, so only a hung handshake trips it.
    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side. Each transfer is preceded by a random stall, unless the current phase
    // has asked for a stall-free stretch. The handshake is judged on the values seen at
    // the clock edge, before the design updates them.
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_no_stalls ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            board.check_result(m_axis_tuser, m_axis_tdata[TX_W-1:0],
                               m_axis_tdata[TX_W+RP_W-1:TX_W], m_axis_tlast);
        end
    end

    function automatic logic [ADC_W-1:0] clamp_adc(int value);
        if (value < 0)
            value = 0;
        if (value > ADC_TOP)
            value = ADC_TOP;
        return value[ADC_W-1:0];
    endfunction

    // Sensor reading whose angle lies just at or below the given one.
    function automatic logic [ADC_W-1:0] adc_near(int angle);
        return clamp_adc((angle <<< ANG_SHIFT) / ADC_GAIN + ADC_OFFSET);
    endfunction

    // Offers one item after a random gap. tvalid is left high on acceptance, so that a
    // following item with no gap goes out back to back; a pause lowers it first.
    task automatic send_item(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] target,
                             logic [ADC_W-1:0] adc);
        int                   gap;
        logic [IN_DATA_W-1:0] word;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word                         = '0;
        word[POS_W-1:0]              = target;
        word[POS_W+ADC_W-1:POS_W]    = adc;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        if (board.note_item(op, target, adc))
            items_sent++;
    endtask

    // Holds the input side off until every expected result transfer has arrived.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic program_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        board.store_register(index, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Only called with the block idle and quiet.
    task automatic apply_setting(int zero, int full, int tol, int dev);
        program_register(REG_ZERO_ANGLE, zero[CFG_W-1:0]);
        program_register(REG_FULL_ANGLE, full[CFG_W-1:0]);
        program_register(REG_TOLERANCE,  tol[CFG_W-1:0]);
        program_register(REG_DEVICE,     dev[CFG_W-1:0]);
        settings_used++;
        rx_no_stalls = ($urandom_range(0, 3) == 0);
    endtask

    // A well-formed move: a start move followed by samples that home in on the goal,
    // with the odd controller reset or unused opcode mixed in, and a final few samples
    // right at the goal so that most moves finish with a report.
    task automatic run_approach();
        int target;
        int pick;
        int base;
        int spread;
        int offset;
        int tries;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            target = 0;
        else if (pick == 1)
            target = PCT_SCALE;
        else
            target = $urandom_range(0, PCT_SCALE);
        send_item(OP_MOVE, target[POS_W-1:0], $urandom_range(0, ADC_TOP));
        base   = adc_near(board.goal_angle);
        spread = $urandom_range(150, 400);
        repeat ($urandom_range(2, 7))
        begin
            offset = $urandom_range(0, 2 * spread);
            offset = offset - spread;
            send_item(OP_SAMPLE, $urandom_range(0, PCT_SCALE), clamp_adc(base + offset));
            spread = spread / 2;
            if ($urandom_range(0, 19) == 0)
                send_item(OP_RESET, $urandom_range(0, PCT_SCALE), $urandom_range(0, ADC_TOP));
            if ($urandom_range(0, 24) == 0)
                send_item(OP_UNUSED, $urandom_range(0, PCT_SCALE), $urandom_range(0, ADC_TOP));
        end
        tries = 0;
        while (board.moving && tries < 4)
        begin
            offset = (tries == 0) ? 0 : $urandom_range(0, 2);
            offset = (tries == 0) ? 0 : offset - 1;
            send_item(OP_SAMPLE, $urandom_range(0, PCT_SCALE), clamp_adc(base + offset));
            tries++;
        end
    endtask

    // Mostly well-formed moves, the rest loose samples, resets, lone moves and items
    // with the unused opcode. At least once per phase the sender waits for the block to
    // drain completely before carrying on.
    task automatic run_random(int count);
        int  stop_at;
        int  pick;
        bit  paused;
        stop_at = items_sent + count;
        paused  = 1'b0;
        while (items_sent < stop_at)
        begin
            tx_no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 65)
                run_approach();
            else if (pick < 80)
                send_item(OP_SAMPLE, $urandom_range(0, PCT_SCALE), $urandom_range(0, ADC_TOP));
            else if (pick < 88)
                send_item(OP_RESET, $urandom_range(0, PCT_SCALE), $urandom_range(0, ADC_TOP));
            else if (pick < 94)
                send_item(OP_MOVE, $urandom_range(0, PCT_SCALE), $urandom_range(0, ADC_TOP));
            else
                send_item(OP_UNUSED, $urandom_range(0, PCT_SCALE), $urandom_range(0, ADC_TOP));
            if ((!paused && items_sent >= stop_at - count / 2) || $urandom_range(0, 15) == 0)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    // Hand-picked items under the reset settings: a span of 0 to 5760 Q4 degrees,
    // a tolerance of 2 degrees and device 0.
    task automatic run_directed();
        tx_no_gaps = 1'b0;
        send_item(OP_SAMPLE, 7'd0, 10'd500);     // no move active, so nothing comes out
        send_item(OP_UNUSED, 7'd100, 10'd1023);  // unused opcode, ignored
        send_item(OP_RESET, 7'd0, 10'd0);        // exit-safe-start bytes
        send_item(OP_MOVE, 7'd100, 10'd0);       // goal at the full angle
        send_item(OP_SAMPLE, 7'd0, 10'd0);       // below the sensor floor, full speed ahead
        send_item(OP_SAMPLE, 7'd0, 10'd0);       // same speed, so no new command
        send_item(OP_SAMPLE, 7'd0, 10'd1023);    // overshoot, reverse in the middle band
        send_item(OP_SAMPLE, 7'd0, 10'd969);     // reverse in the slow band
        send_item(OP_SAMPLE, 7'd0, 10'd934);     // reverse at the lowest speed
        send_item(OP_MOVE, 7'd50, 10'd0);        // new goal mid move, speed is kept
        send_item(OP_SAMPLE, 7'd0, 10'd100);
        send_item(OP_SAMPLE, 7'd0, 10'd101);
        send_item(OP_SAMPLE, 7'd0, 10'd511);     // within tolerance: stop and report
        send_item(OP_SAMPLE, 7'd0, 10'd511);     // move over, ignored
        send_item(OP_MOVE, 7'd0, 10'd0);
        send_item(OP_SAMPLE, 7'd0, 10'd102);     // already stopped, so only the report
        send_item(OP_MOVE, 7'd100, 10'd0);
        send_item(OP_SAMPLE, 7'd0, 10'd0);
        send_item(OP_RESET, 7'd0, 10'd0);        // clears the speed while still moving
        send_item(OP_SAMPLE, 7'd0, 10'd0);       // so the same speed is sent again
        send_item(OP_SAMPLE, 7'd0, 10'd921);     // just short of the full angle
        tx_no_gaps = 1'b1;
        send_item(OP_MOVE, 7'd64, 10'd682);
        send_item(OP_SAMPLE, 7'd1, 10'd341);
        send_item(OP_SAMPLE, 7'd2, 10'd751);
        tx_no_gaps = 1'b0;
    endtask

    initial
    begin
        int zero;
        int full;
        int tol;
        board = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        items_sent    = 0;
        settings_used = 1;
        tx_no_gaps    = 1'b0;
        rx_no_stalls  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(ITEMS_PER_PHASE);
        settle();

        // Extremes: lowest angles, zero tolerance and the top device number. A goal at
        // the sensor floor can be hit exactly even with no tolerance at all.
        apply_setting(ANG_FLOOR, 5760, 0, 127);
        send_item(OP_MOVE, 7'd0, 10'd0);
        send_item(OP_SAMPLE, 7'd0, 10'd50);
        run_random(ITEMS_PER_PHASE);
        settle();

        // Span running backwards, widest tolerance.
        apply_setting(5760, ANG_FLOOR, 1023, 85);
        run_random(ITEMS_PER_PHASE);
        settle();

        // Equal zero and full angles: every report must read zero.
        apply_setting(1000, 1000, 64, 42);
        run_random(ITEMS_PER_PHASE);
        settle();

        // A tiny reversed span drives the report into both saturation limits.
        apply_setting(5760, 5744, 1023, 1);
        run_random(ITEMS_PER_PHASE);
        settle();

        repeat (RANDOM_PHASES)
        begin
            zero = $urandom_range(0, 5776);
            full = $urandom_range(0, 5776);
            tol  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 1023);
            apply_setting(zero + ANG_FLOOR, full + ANG_FLOOR, tol, $urandom_range(0, 127));
            run_random(ITEMS_PER_PHASE);
            settle();
        end

        if (board.outstanding() != 0)
        begin
            $error("%0d expected result transfers never arrived", board.outstanding());
            board.errors++;
        end
        $display("Summary: %0d items acted on, %0d result transfers checked, %0d settings.",
                 items_sent, board.results_checked, settings_used);
        $display("Summary: %0d mismatches or stray transfers seen.", board.errors);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
rtl/bpmc_pkg.sv
rtl/bpmc_div.sv
rtl/banded_position_motor_controller.sv
bench/testbench.sv
